@@ design/tpc_pkg.sv @@
package tpc_pkg;

  localparam int SYMBOL_W = 5;
  localparam int OUT_COUNT_W = 16;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_COUNT
  } tpc_state_t;

endpackage

@@ design/trie_prefix_counter_unit.sv @@
// channel  | ports                                          | dir
// ---------+------------------------------------------------+-----
// in       | in_valid in_ready in_kind in_symbol in_first   | in
//          | in_last                                        |
// out      | out_valid out_ready out_kind_echo              | out
//          | out_prefix_count out_pool_full                 |
//
// each letter takes the child pointer read, then the pass count read
// and its write back, which overlaps the next letter's child pointer read
// after reset the child table is cleared, one entry a cycle, all
// NODE_POOL*ALPHABET entries (106496 by default); in_ready stays low meanwhile
// pass counts are written when a node is allocated, so they need no clearing
// a word-end result waits in the output register; while it cannot leave, the
// next word-end result holds the count stage and in_ready stays low
module trie_prefix_counter_unit
  import tpc_pkg::*;
#(
  parameter int NODE_POOL = 4096,
  parameter int ALPHABET = 26,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_kind,
  input  logic [SYMBOL_W-1:0]    in_symbol,
  input  logic                   in_first,
  input  logic                   in_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_kind_echo,
  output logic [OUT_COUNT_W-1:0] out_prefix_count,
  output logic                   out_pool_full
);

  localparam int NODE_W = $clog2(NODE_POOL);
  localparam int NF_W = $clog2(NODE_POOL + 1);
  localparam int CHILD_DEPTH = NODE_POOL * ALPHABET;
  localparam int CADDR_W = $clog2(CHILD_DEPTH);
  localparam int SYM_CMP_W = 9;
  localparam int EXT_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam logic [CADDR_W-1:0] ALPHA_C = CADDR_W'(ALPHABET);
  localparam logic [CADDR_W-1:0] CLR_LAST = CADDR_W'(CHILD_DEPTH - 1);
  localparam logic [NF_W-1:0] POOL_END = NF_W'(NODE_POOL);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [EXT_W-1:0] OUT_MAX_EXT = EXT_W'({OUT_COUNT_W{1'b1}});

  tpc_state_t state_r, state_nxt;

  logic [CADDR_W-1:0] clr_addr_r;
  logic [NODE_W-1:0]  cur_node_r, cur_node_nxt;
  logic               missed_r, missed_nxt;
  logic               over_r, over_nxt;
  logic [NF_W-1:0]    next_free_r, next_free_nxt;

  logic               lk_kind_r;
  logic               lk_last_r;
  logic               lk_oob_r;
  logic [CADDR_W-1:0] lk_slot_r;

  logic               cn_inc_r, cn_inc_nxt;
  logic               cn_res_r, cn_res_nxt;
  logic               cn_kind_r, cn_kind_nxt;
  logic               cn_over_r, cn_over_nxt;
  logic               cn_hit_r, cn_hit_nxt;
  logic [NODE_W-1:0]  cn_node_r, cn_node_nxt;

  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic                   out_full_r;

  logic               accept;
  logic               stall;
  logic               load_out;
  logic               sym_oob;
  logic [NODE_W-1:0]  eff_node;
  logic [CADDR_W-1:0] slot_in;

  logic               child_we;
  logic [CADDR_W-1:0] child_waddr;
  logic [NODE_W-1:0]  child_wdata;
  logic               child_re;
  logic [NODE_W-1:0]  child_rdata;

  logic                  pass_we;
  logic [NODE_W-1:0]     pass_waddr;
  logic [COUNT_BITS-1:0] pass_wdata;
  logic                  pass_re;
  logic [NODE_W-1:0]     pass_raddr;
  logic [COUNT_BITS-1:0] pass_rdata;
  logic [EXT_W-1:0]      pass_ext;
  logic [OUT_COUNT_W-1:0] answer;

  tpc_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child_ram (
    .clk   (clk),
    .we    (child_we),
    .waddr (child_waddr),
    .wdata (child_wdata),
    .re    (child_re),
    .raddr (slot_in),
    .rdata (child_rdata)
  );

  tpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NODE_POOL)) u_pass_ram (
    .clk   (clk),
    .we    (pass_we),
    .waddr (pass_waddr),
    .wdata (pass_wdata),
    .re    (pass_re),
    .raddr (pass_raddr),
    .rdata (pass_rdata)
  );

  // control outputs
  always_comb begin
    stall    = (state_r == ST_COUNT) && cn_res_r && out_valid_r && !out_ready;
    in_ready = (state_r == ST_IDLE) || ((state_r == ST_COUNT) && !stall);
    load_out = (state_r == ST_COUNT) && cn_res_r && !stall;
  end

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_nxt = ST_COUNT;
      end
      ST_COUNT: begin
        if (stall) begin
          state_nxt = ST_COUNT;
        end else if (accept) begin
          state_nxt = ST_LOOK;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // slot address of the accepted letter
  always_comb begin
    sym_oob  = SYM_CMP_W'(in_symbol) >= SYM_CMP_W'(ALPHABET);
    eff_node = in_first ? '0 : cur_node_r;
    slot_in  = CADDR_W'(eff_node) * ALPHA_C + CADDR_W'(in_symbol);
    child_re = accept && !sym_oob;
  end

  // walk step and count stage
  always_comb begin
    cur_node_nxt  = cur_node_r;
    missed_nxt    = missed_r;
    over_nxt      = over_r;
    next_free_nxt = next_free_r;
    cn_inc_nxt    = cn_inc_r;
    cn_res_nxt    = cn_res_r;
    cn_kind_nxt   = cn_kind_r;
    cn_over_nxt   = cn_over_r;
    cn_hit_nxt    = cn_hit_r;
    cn_node_nxt   = cn_node_r;
    child_we      = 1'b0;
    child_waddr   = lk_slot_r;
    child_wdata   = next_free_r[NODE_W-1:0];
    pass_we       = 1'b0;
    pass_waddr    = next_free_r[NODE_W-1:0];
    pass_wdata    = COUNT_BITS'(1);
    pass_re       = 1'b0;
    pass_raddr    = child_rdata;

    if (state_r == ST_CLEAR) begin
      child_we    = 1'b1;
      child_waddr = clr_addr_r;
      child_wdata = '0;
    end

    if (accept && in_first) begin
      cur_node_nxt = '0;
      missed_nxt   = 1'b0;
      over_nxt     = 1'b0;
    end

    if (state_r == ST_COUNT && !stall) begin
      if (cn_inc_r) begin
        pass_we    = 1'b1;
        pass_waddr = cn_node_r;
        pass_wdata = (pass_rdata == COUNT_MAX) ? pass_rdata : pass_rdata + 1'b1;
      end
      cn_inc_nxt = 1'b0;
      cn_res_nxt = 1'b0;
    end

    if (state_r == ST_LOOK) begin
      cn_inc_nxt = 1'b0;
      cn_hit_nxt = 1'b0;
      if (!missed_r && !over_r) begin
        if (lk_oob_r) begin
          missed_nxt = 1'b1;
        end else if (child_rdata == '0) begin
          if (lk_kind_r) begin
            missed_nxt = 1'b1;
          end else if (next_free_r == POOL_END) begin
            over_nxt = 1'b1;
          end else begin
            child_we      = 1'b1;
            pass_we       = 1'b1;
            cur_node_nxt  = next_free_r[NODE_W-1:0];
            next_free_nxt = next_free_r + 1'b1;
          end
        end else begin
          cur_node_nxt = child_rdata;
          cn_node_nxt  = child_rdata;
          pass_re      = 1'b1;
          cn_inc_nxt   = !lk_kind_r;
          cn_hit_nxt   = lk_kind_r;
        end
      end
      cn_res_nxt  = lk_last_r;
      cn_kind_nxt = lk_kind_r;
      cn_over_nxt = over_nxt;
      if (lk_last_r) begin
        cur_node_nxt = '0;
        missed_nxt   = 1'b0;
        over_nxt     = 1'b0;
      end
    end
  end

  // saturate the count to the result width
  always_comb begin
    pass_ext = EXT_W'(pass_rdata);
    answer   = (pass_ext > OUT_MAX_EXT) ? OUT_MAX_EXT[OUT_COUNT_W-1:0]
                                        : pass_ext[OUT_COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      cur_node_r  <= '0;
      missed_r    <= 1'b0;
      over_r      <= 1'b0;
      next_free_r <= NF_W'(1);
      cn_inc_r    <= 1'b0;
      cn_res_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_node_r  <= cur_node_nxt;
      missed_r    <= missed_nxt;
      over_r      <= over_nxt;
      next_free_r <= next_free_nxt;
      cn_inc_r    <= cn_inc_nxt;
      cn_res_r    <= cn_res_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lk_kind_r <= in_kind;
      lk_last_r <= in_last;
      lk_oob_r  <= sym_oob;
      lk_slot_r <= slot_in;
    end
    cn_kind_r <= cn_kind_nxt;
    cn_over_r <= cn_over_nxt;
    cn_hit_r  <= cn_hit_nxt;
    cn_node_r <= cn_node_nxt;
    if (load_out) begin
      out_kind_r  <= cn_kind_r;
      out_count_r <= cn_hit_r ? answer : '0;
      out_full_r  <= cn_over_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind_echo    = out_kind_r;
  assign out_prefix_count = out_count_r;
  assign out_pool_full    = out_full_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("letter accepted during table clear");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= POOL_END)
    else $error("node pool pointer past end");

  a_node_allocated: assert property (@(posedge clk) disable iff (!rst_n)
    NF_W'(cur_node_r) < next_free_r)
    else $error("walk on an unallocated node");

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_LOOK))
    else $error("accepted letter did not start a child lookup");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> (state_r == ST_COUNT) && cn_res_r)
    else $error("pending word result dropped under stall");

endmodule

@@ design/tpc_ram.sv @@
module tpc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
